>>> hw/rtl/aesbe_pkg.sv
// ----------------------------------------------------------------------------
// aesbe_pkg: shared types, constants and GF(2^8) helpers
// Controller states, the command bundle to the datapath, the S-box table and
// the MixColumns arithmetic used by the AES-128 block encrypt core.
// ----------------------------------------------------------------------------
package aesbe_pkg;

  localparam int NUM_ROUND_KEYS = 11;
  localparam int LAST_ROUND     = NUM_ROUND_KEYS - 1;
  localparam int ROUND_W        = $clog2(NUM_ROUND_KEYS);
  localparam int BLOCK_W        = 128;
  localparam int HALF_W         = 64;

  localparam logic KIND_LOAD_KEY = 1'b0;
  localparam logic KIND_ENCRYPT  = 1'b1;

  localparam logic [8:0] GF_POLY = 9'h11b;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } aesbe_state_t;

  typedef struct packed {
    logic               key_we;      // write round key from input transaction
    logic               load_block;  // capture plaintext into state register
    logic               step;        // advance state register by one round
    logic               first;       // initial AddRoundKey only
    logic               last;        // final round, no MixColumns
    logic               capture;     // load round output into result register
    logic [ROUND_W-1:0] rd_addr;     // round key index for this cycle
  } aesbe_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    logic [8:0] sh;
    sh = {b, 1'b0};
    if (b[7]) begin
      sh = sh ^ GF_POLY;
    end
    return sh[7:0];
  endfunction

  function automatic logic [31:0] mix_column(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] b0, b1, b2, b3;
    a0 = w[31:24];
    a1 = w[23:16];
    a2 = w[15:8];
    a3 = w[7:0];
    b0 = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
    b1 = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
    b2 = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
    b3 = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    return {b0, b1, b2, b3};
  endfunction

endpackage

>>> hw/rtl/aesbe_dp.sv
// ----------------------------------------------------------------------------
// aesbe_dp: AES-128 round datapath
// Round key store, 128-bit state register, one-round combinational unit and
// the result register. Driven by commands from the controller.
// ----------------------------------------------------------------------------
module aesbe_dp (
  input  logic                              clk,
  input  aesbe_pkg::aesbe_cmd_t             cmd,
  input  logic [aesbe_pkg::ROUND_W-1:0]     key_round,
  input  logic [aesbe_pkg::HALF_W-1:0]      block_high,
  input  logic [aesbe_pkg::HALF_W-1:0]      block_low,
  output logic [aesbe_pkg::HALF_W-1:0]      cipher_high,
  output logic [aesbe_pkg::HALF_W-1:0]      cipher_low
);
  import aesbe_pkg::*;

  logic [BLOCK_W-1:0] key_store [NUM_ROUND_KEYS];
  logic [BLOCK_W-1:0] blk;
  logic [BLOCK_W-1:0] cipher;
  logic [BLOCK_W-1:0] round_key;
  logic [BLOCK_W-1:0] sub_shift;
  logic [BLOCK_W-1:0] mixed;
  logic [BLOCK_W-1:0] round_out;
  logic               key_in_range;

  assign key_in_range = (key_round < ROUND_W'(NUM_ROUND_KEYS));
  assign round_key    = key_store[cmd.rd_addr];

  // SubBytes and ShiftRows: row r of column c comes from column (c + r) mod 4
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sub_shift[BLOCK_W-1-32*c-8*r -: 8] =
          sub_byte(blk[BLOCK_W-1-32*((c+r)&3)-8*r -: 8]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mixed[BLOCK_W-1-32*c -: 32] = mix_column(sub_shift[BLOCK_W-1-32*c -: 32]);
    end
  end

  always_comb begin
    if (cmd.first) begin
      round_out = blk ^ round_key;
    end else if (cmd.last) begin
      round_out = sub_shift ^ round_key;
    end else begin
      round_out = mixed ^ round_key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_we && key_in_range) begin
      key_store[key_round] <= {block_high, block_low};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_block) begin
      blk <= {block_high, block_low};
    end else if (cmd.step) begin
      blk <= round_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cipher <= round_out;
    end
  end

  assign cipher_high = cipher[BLOCK_W-1:HALF_W];
  assign cipher_low  = cipher[HALF_W-1:0];

endmodule

>>> hw/rtl/aesbe_ctrl.sv
// ----------------------------------------------------------------------------
// aesbe_ctrl: AES-128 round sequencer
// Accepts transactions, counts rounds, issues datapath commands and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module aesbe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  output logic                  out_valid,
  input  logic                  out_stall,
  output aesbe_pkg::aesbe_cmd_t cmd
);
  import aesbe_pkg::*;

  aesbe_state_t       state, state_next;
  logic [ROUND_W-1:0] rnd, rnd_next;
  logic               out_valid_next;
  logic               in_accept;
  logic               out_free;
  logic               at_last;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign at_last   = (rnd == ROUND_W'(LAST_ROUND));

  // next state
  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    case (state)
      ST_IDLE: begin
        if (in_accept && kind == KIND_ENCRYPT) begin
          state_next = ST_RUN;
          rnd_next   = '0;
        end
      end
      ST_RUN: begin
        if (at_last) begin
          if (out_free) begin
            state_next = ST_IDLE;
          end
        end else begin
          rnd_next = rnd + ROUND_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall        = 1'b1;
    cmd.key_we      = 1'b0;
    cmd.load_block  = 1'b0;
    cmd.step        = 1'b0;
    cmd.first       = 1'b0;
    cmd.last        = 1'b0;
    cmd.capture     = 1'b0;
    cmd.rd_addr     = rnd;
    case (state)
      ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.key_we     = in_valid && kind == KIND_LOAD_KEY;
        cmd.load_block = in_valid && kind == KIND_ENCRYPT;
      end
      ST_RUN: begin
        cmd.first   = (rnd == '0);
        cmd.last    = at_last;
        cmd.step    = !at_last;
        cmd.capture = at_last && out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cmd.capture) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> hw/rtl/aes128_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// aes128_block_encrypt_top: AES-128 ECB block encryption core
// Encrypt transaction: one AddRoundKey plus ten rounds, one round per cycle
// through a single round unit, held only in the final round while the result
// register is occupied and stalled. Input waits until the encryption ends.
// Reset (synchronous, rst high) clears control only; round keys are undefined.
// ----------------------------------------------------------------------------
//
// Transactions on the input channel:
//   kind = 0 : load round key block_high/block_low into slot key_round.
//              Slots 11..15 are ignored. No result is produced.
//   kind = 1 : encrypt the 128-bit block. Word 0 is block_high[63:32], each
//              32-bit word is a column with row 0 in the top byte.
//
// Structure:
//   aesbe_ctrl - two-state sequencer (idle / run), round counter, result
//                valid flag. Input is taken only while idle.
//   aesbe_dp   - 11 x 128-bit key store, state register, one round of
//                SubBytes/ShiftRows/MixColumns/AddRoundKey, result register.
//
// Round counter value 0 does the initial AddRoundKey, 1..9 full rounds,
// 10 the final round (no MixColumns) which writes the result register.
// The result register decouples the output: the core may run the next block
// while the previous ciphertext waits; it only holds in the last round if
// that register is still occupied and stalled.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [3:0]  key_round,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low
);
  import aesbe_pkg::*;

  aesbe_cmd_t cmd;

  aesbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  aesbe_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .key_round   (key_round),
    .block_high  (block_high),
    .block_low   (block_low),
    .cipher_high (cipher_high),
    .cipher_low  (cipher_low)
  );

endmodule

>>> tb/aes128_block_encrypt_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_encrypt_top_tb: self-checking bench for the AES-128 ECB core
// Round-key loads and block encryptions are queued and sent over the valid/
// stall input channel. Each accepted encryption is predicted by an independent
// AES cipher, with the S-box derived from GF(2^8) inversion. Each ciphertext
// is checked in order against that prediction.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top_tb;
  import aesbe_pkg::*;

  typedef struct {
    logic        kind;
    logic [3:0]  slot;
    logic [63:0] hi;
    logic [63:0] lo;
    bit          hold_for_drain;  // wait until all ciphertexts are back
  } aes_txn_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = KIND_LOAD_KEY;
  logic [3:0]  key_round = 4'd0;
  logic [63:0] block_high = 64'd0;
  logic [63:0] block_low = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;

  aes128_block_encrypt_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .key_round(key_round),
    .block_high(block_high),
    .block_low(block_low),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cipher_high(cipher_high),
    .cipher_low(cipher_low)
  );

  // Stimulus queue (filled by the sequence block) and expected ciphertexts.
  aes_txn_t     pending_txns[$];
  logic [127:0] cipher_expected[$];

  // Predictor state: our own copy of the round-key store and S-box.
  logic [127:0] round_keys [NUM_ROUND_KEYS];
  logic [7:0]   sbox_tbl [256];

  // Handshake bookkeeping, set at the rising edge, used at the falling edge.
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  int txn_accepted = 0;
  int key_loads = 0;
  int ignored_loads = 0;
  int blocks_checked = 0;
  int mismatch_count = 0;
  int send_gap = 0;
  int rx_wait = 0;
  int hold_left = 0;
  int holds_done = 0;
  aes_txn_t cur_txn;
  logic [127:0] want_block;

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the core hangs.
  initial begin
    #1000000;
    $display("aes128_block_encrypt_top_tb failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Plain shift-and-add multiply in GF(2^8) mod x^8+x^4+x^3+x+1.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] aa;
    acc = 8'd0;
    aa = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ aa;
      aa = aa[7] ? ({aa[6:0], 1'b0} ^ 8'h1b) : {aa[6:0], 1'b0};
    end
    return acc;
  endfunction

  // S-box = affine transform of the multiplicative inverse (0 maps to 0).
  task automatic build_sbox();
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'd0;
      for (int y = 1; y < 256; y++) begin
        if (x != 0 && gf_mul(x[7:0], y[7:0]) == 8'd1) inv = y[7:0];
      end
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_tbl[x] = s;
    end
  endtask

  // Full AES-128 cipher using the currently loaded round keys.
  // State byte for column c, row r lives at bits 127-32c-8r.
  function automatic logic [127:0] encrypt_block(input logic [127:0] plain);
    logic [127:0] acc;
    logic [7:0]   st [4][4];
    logic [7:0]   a0, a1, a2, a3;
    acc = plain ^ round_keys[0];
    for (int rnd = 1; rnd < NUM_ROUND_KEYS; rnd++) begin
      // SubBytes and ShiftRows: row r rotates left by r columns
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          st[c][r] = sbox_tbl[acc[127 - 32*((c + r) % 4) - 8*r -: 8]];
        end
      end
      if (rnd != NUM_ROUND_KEYS - 1) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[c][0];
          a1 = st[c][1];
          a2 = st[c][2];
          a3 = st[c][3];
          st[c][0] = gf_mul(8'd2, a0) ^ gf_mul(8'd3, a1) ^ a2 ^ a3;
          st[c][1] = a0 ^ gf_mul(8'd2, a1) ^ gf_mul(8'd3, a2) ^ a3;
          st[c][2] = a0 ^ a1 ^ gf_mul(8'd2, a2) ^ gf_mul(8'd3, a3);
          st[c][3] = gf_mul(8'd3, a0) ^ a1 ^ a2 ^ gf_mul(8'd2, a3);
        end
      end
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          acc[127 - 32*c - 8*r -: 8] = st[c][r];
        end
      end
      acc = acc ^ round_keys[rnd];
    end
    return acc;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Per-transaction idle draw; every fourth stretch of 250 transactions runs
  // with no idling at all on either side.
  function automatic int idle_draw();
    if ((txn_accepted / 250) % 4 == 3) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("MISMATCH %0t: %s got %h want %h", $time, what, got, want);
  endtask

  task automatic queue_load(input logic [3:0] slot, input logic [63:0] hi,
                            input logic [63:0] lo);
    aes_txn_t t;
    t.kind = KIND_LOAD_KEY;
    t.slot = slot;
    t.hi = hi;
    t.lo = lo;
    t.hold_for_drain = 1'b0;
    pending_txns.push_back(t);
  endtask

  task automatic queue_encrypt(input logic [63:0] hi, input logic [63:0] lo,
                               input bit drain);
    aes_txn_t t;
    t.kind = KIND_ENCRYPT;
    t.slot = 4'($urandom_range(0, 15));  // don't care for encrypts
    t.hi = hi;
    t.lo = lo;
    t.hold_for_drain = drain;
    pending_txns.push_back(t);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: changes at the falling edge, one transaction at a time.
  // Valid stays up with a stable payload until the core takes it.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // stalled: hold everything
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_txns.size() > 0 &&
                 !(pending_txns[0].hold_for_drain && cipher_expected.size() != 0)) begin
      cur_txn = pending_txns.pop_front();
      kind <= cur_txn.kind;
      key_round <= cur_txn.slot;
      block_high <= cur_txn.hi;
      block_low <= cur_txn.lo;
      in_valid <= 1'b1;
      send_gap = idle_draw();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Output receiver: random stall per result, plus long hold-offs.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire) rx_wait = idle_draw();
      out_stall <= (rx_wait != 0) || (hold_left != 0);
      if (out_valid && rx_wait != 0) rx_wait = rx_wait - 1;
    end
  end

  // Long hold-off, counted here: the sender keeps offering transactions,
  // so the core fills its result register and backs up into in_stall.
  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && txn_accepted >= 500 + 900 * holds_done) begin
      hold_left <= 120;
      holds_done <= holds_done + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge, predict and check.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      out_fire <= out_valid && !out_stall;

      if (in_valid && !in_stall) begin
        txn_accepted++;
        if (kind == KIND_LOAD_KEY) begin
          key_loads++;
          // slots past the last round key are dropped by the core
          if (key_round < NUM_ROUND_KEYS) round_keys[key_round] = {block_high, block_low};
          else ignored_loads++;
        end else begin
          cipher_expected.push_back(encrypt_block({block_high, block_low}));
        end
      end

      if (out_valid && !out_stall) begin
        if (cipher_expected.size() == 0) begin
          report_mismatch("unexpected ciphertext, high", cipher_high, 64'd0);
        end else begin
          want_block = cipher_expected.pop_front();
          blocks_checked++;
          if (cipher_high !== want_block[127:64])
            report_mismatch("cipher_high", cipher_high, want_block[127:64]);
          if (cipher_low !== want_block[63:0])
            report_mismatch("cipher_low", cipher_low, want_block[63:0]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed transactions, random traffic, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin
    int sent;
    int pick;

    build_sbox();

    // Directed: fill every key slot first so no encrypt reads an empty slot.
    // Extremes: slot 0 all zeros, slot 10 all ones.
    queue_load(4'd0, 64'd0, 64'd0);
    for (int k = 1; k < NUM_ROUND_KEYS - 1; k++) queue_load(4'(k), rand64(), rand64());
    queue_load(4'd10, '1, '1);
    // Loads to slots past the end must change nothing.
    queue_load(4'd11, rand64(), rand64());
    queue_load(4'd15, '1, '1);
    // Extreme and patterned plaintexts, back to back.
    queue_encrypt(64'd0, 64'd0, 1'b0);
    queue_encrypt('1, '1, 1'b0);
    queue_encrypt(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    queue_encrypt(64'h55aa55aa55aa55aa, 64'haa55aa55aa55aa55, 1'b0);
    // Overwrite slots after use, then encrypt again after a full drain.
    queue_load(4'd0, '1, '1);
    queue_load(4'd5, 64'd0, 64'd0);
    queue_encrypt(64'd0, 64'd0, 1'b0);
    queue_encrypt('1, '1, 1'b1);

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Random traffic: mostly encryptions, with single key updates, whole
    // key-set reloads and a few dropped loads mixed in.
    sent = 0;
    while (sent < 1950) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        for (int k = 0; k < NUM_ROUND_KEYS; k++) queue_load(4'(k), rand64(), rand64());
        sent += NUM_ROUND_KEYS;
      end else if (pick < 18) begin
        queue_load(4'($urandom_range(0, NUM_ROUND_KEYS - 1)), rand64(), rand64());
        sent++;
      end else if (pick < 22) begin
        queue_load(4'($urandom_range(NUM_ROUND_KEYS, 15)), rand64(), rand64());
        sent++;
      end else if (pick < 25) begin
        queue_encrypt(($urandom_range(0, 1) != 0) ? '1 : 64'd0,
                      ($urandom_range(0, 1) != 0) ? '1 : 64'd0, 1'b0);
        sent++;
      end else begin
        // sender pauses for a full drain now and then
        queue_encrypt(rand64(), rand64(), (sent % 400) == 399);
        sent++;
      end
    end

    // Everything sent, then everything back, then let stray results show up.
    while (pending_txns.size() != 0 || in_valid) @(posedge clk);
    while (cipher_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d transactions: %0d key loads (%0d to unused slots)",
             txn_accepted, key_loads, ignored_loads);
    $display("%0d ciphertexts checked, %0d long output hold-offs, %0d mismatches",
             blocks_checked, holds_done, mismatch_count);
    if (mismatch_count == 0) begin
      $display("aes128_block_encrypt_top_tb passed");
    end else begin
      $display("aes128_block_encrypt_top_tb failed");
    end
    $finish;
  end

endmodule
